>>> sv/bpcf_pkg.sv
`timescale 1ns / 1ps
package bpcf_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int P_W     = 18;
  localparam int Q_W     = 26;
  localparam int MUL_W   = 60;
  localparam int DIV_W   = 35;
  localparam int DEN_W   = 8;
  localparam int CNT_W   = 6;
  localparam int DT_W    = 25;
  localparam int OFF_W   = 37;
  localparam int SENS_W  = 36;
  localparam int DIFF_W  = 27;
  localparam int MAG_W   = 12;
  localparam int ADQ_W   = 9;

  localparam logic [P_W-1:0] P_MAX    = 18'h3FFFF;
  localparam logic [Q_W-1:0] SLOW_MAX = 26'h3FFFFFF;

  localparam logic [DEN_W-1:0] SLOW_DEN  = 8'd200;
  localparam logic [DEN_W-1:0] ADJ_DEN   = 8'd6;
  localparam logic [DIV_W-1:0] SLOW_KEEP = 35'd197;
  localparam logic [DIV_W-1:0] SLOW_GAIN = 35'd3;
  localparam logic [DIV_W-1:0] SLOW_RND  = 35'd100;
  localparam int               DIFF_CLAMP = 2048;
  localparam int               DIFF_DEAD  = 256;

  localparam int ADJ_BITS = 12;
  localparam int C4_BITS  = 16;
  localparam int D1_BITS  = 24;

  // register indexes on the configuration port
  localparam logic [2:0] REG_SENS      = 3'd0;
  localparam logic [2:0] REG_OFFSET    = 3'd1;
  localparam logic [2:0] REG_SENS_TEMP = 3'd2;
  localparam logic [2:0] REG_OFF_TEMP  = 3'd3;
  localparam logic [2:0] REG_REF_TEMP  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TDIV,
    ST_DT,
    ST_MOFF,
    ST_OFF,
    ST_MSENS,
    ST_SENS,
    ST_MP,
    ST_PRES,
    ST_PSUM,
    ST_FDIV,
    ST_SLOW,
    ST_SDIV,
    ST_ADJ,
    ST_ADIV,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

>>> sv/bpcf_ram.sv
`timescale 1ns / 1ps
module bpcf_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 20
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/baro_pressure_compensate_filter.sv
`timescale 1ns / 1ps
// One shared shift-add multiplier (one multiplier bit per cycle) and one restoring divider
//   (one quotient bit per cycle) carry all the steps; the adjust divide is skipped when
//   slow and fast lie within 1 Pa.
// Throughput: one item at a time; the next item is taken once the result has entered the
//   output register, which waits while a stalled earlier result still holds it. Pressure
//   items skip the temperature divide. Reset (rst_n, synchronous): clears the state, sums,
//   ring positions, ring valid bits and the temperature ring.
module baro_pressure_compensate_filter #(
  parameter int TEMP_TAPS     = 5,
  parameter int PRESSURE_TAPS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [23:0] in_raw_reading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [17:0] out_compensated_pressure,
  output logic [25:0] out_fast_pressure,
  output logic [25:0] out_filtered_pressure,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int TAW = (TEMP_TAPS > 1) ? $clog2(TEMP_TAPS) : 1;
  localparam int PAW = (PRESSURE_TAPS > 1) ? $clog2(PRESSURE_TAPS) : 1;
  localparam int TSW = bpcf_pkg::RAW_W + $clog2(TEMP_TAPS);
  localparam int PSW = bpcf_pkg::P_W + $clog2(PRESSURE_TAPS);
  localparam int FNW = PSW + 8;
  localparam logic [TAW-1:0] TLAST = TAW'(TEMP_TAPS - 1);
  localparam logic [PAW-1:0] PLAST = PAW'(PRESSURE_TAPS - 1);
  localparam logic [bpcf_pkg::DEN_W-1:0] TDEN = bpcf_pkg::DEN_W'(TEMP_TAPS);
  localparam logic [bpcf_pkg::DEN_W-1:0] PDEN = bpcf_pkg::DEN_W'(PRESSURE_TAPS);

  // configuration
  logic [15:0] c1_r, c2_r, c3_r, c4_r, c5_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bpcf_pkg::REG_SENS:      c1_r <= cfg_pwdata[15:0];
        bpcf_pkg::REG_OFFSET:    c2_r <= cfg_pwdata[15:0];
        bpcf_pkg::REG_SENS_TEMP: c3_r <= cfg_pwdata[15:0];
        bpcf_pkg::REG_OFF_TEMP:  c4_r <= cfg_pwdata[15:0];
        bpcf_pkg::REG_REF_TEMP:  c5_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bpcf_pkg::REG_SENS:      cfg_prdata = {16'd0, c1_r};
      bpcf_pkg::REG_OFFSET:    cfg_prdata = {16'd0, c2_r};
      bpcf_pkg::REG_SENS_TEMP: cfg_prdata = {16'd0, c3_r};
      bpcf_pkg::REG_OFF_TEMP:  cfg_prdata = {16'd0, c4_r};
      bpcf_pkg::REG_REF_TEMP:  cfg_prdata = {16'd0, c5_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // state
  bpcf_pkg::state_t state_r, state_nxt;

  logic [23:0]          tring_r [TEMP_TAPS];
  logic [23:0]          tring_wdata;
  logic                 tring_we;
  logic [TAW-1:0]       tpos_r, tpos_nxt;
  logic [TSW-1:0]       tsum_r, tsum_nxt;
  logic [23:0]          avg_r, avg_nxt;
  logic [23:0]          d1_r, d1_nxt;
  logic [PAW-1:0]       ppos_r, ppos_nxt;
  logic [PSW-1:0]       psum_r, psum_nxt;
  logic [PRESSURE_TAPS-1:0] pvalid_r, pvalid_nxt;
  logic [25:0]          slow_r, slow_nxt;

  // shared multiplier
  logic signed [bpcf_pkg::MUL_W-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [23:0]          mplier_r, mplier_nxt;
  logic [bpcf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // shared divider
  logic [bpcf_pkg::DIV_W-1:0] dv_r, dv_nxt;
  logic [bpcf_pkg::DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;

  // step results
  logic signed [bpcf_pkg::DT_W-1:0]   dt_r, dt_nxt;
  logic signed [bpcf_pkg::OFF_W-1:0]  off_r, off_nxt;
  logic [17:0]          pc_r, pc_nxt;
  logic [25:0]          fast_r, fast_nxt;
  logic [25:0]          slowq_r, slowq_nxt;
  logic                 neg_r, neg_nxt;

  logic                 ovalid_r, ovalid_nxt;
  logic [17:0]          opc_r, opc_nxt;
  logic [25:0]          ofast_r, ofast_nxt;
  logic [25:0]          oslow_r, oslow_nxt;

  // RAM port
  logic                 pr_we;
  logic [17:0]          pr_rdata;

  bpcf_ram #(
    .WIDTH (bpcf_pkg::P_W),
    .DEPTH (PRESSURE_TAPS)
  ) u_pring (
    .clk   (clk),
    .we    (pr_we),
    .waddr (ppos_r),
    .wdata (pc_r),
    .raddr (ppos_r),
    .rdata (pr_rdata)
  );

  logic accept;
  assign accept    = in_valid & ~in_stall;
  assign in_stall  = (state_r != bpcf_pkg::ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_compensated_pressure = opc_r;
  assign out_fast_pressure        = ofast_r;
  assign out_filtered_pressure    = oslow_r;

  always_comb begin
    logic [bpcf_pkg::DEN_W:0]           r2;
    logic                               ge;
    logic signed [bpcf_pkg::SENS_W-1:0] sens;
    logic signed [39:0]                 ptmp;
    logic signed [24:0]                 pval;
    logic [17:0]                        pold;
    logic [TSW-1:0]                     tsum_new;
    logic [PSW-1:0]                     psum_new;
    logic signed [bpcf_pkg::DIFF_W-1:0] diff;
    logic [bpcf_pkg::MAG_W-1:0]         mag;
    logic signed [27:0]                 snew;

    state_nxt   = state_r;
    tpos_nxt    = tpos_r;
    tsum_nxt    = tsum_r;
    avg_nxt     = avg_r;
    d1_nxt      = d1_r;
    ppos_nxt    = ppos_r;
    psum_nxt    = psum_r;
    pvalid_nxt  = pvalid_r;
    slow_nxt    = slow_r;
    acc_nxt     = acc_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    cnt_nxt     = cnt_r;
    dv_nxt      = dv_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    dt_nxt      = dt_r;
    off_nxt     = off_r;
    pc_nxt      = pc_r;
    fast_nxt    = fast_r;
    slowq_nxt   = slowq_r;
    neg_nxt     = neg_r;
    ovalid_nxt  = ovalid_r & out_stall;
    opc_nxt     = opc_r;
    ofast_nxt   = ofast_r;
    oslow_nxt   = oslow_r;
    tring_we    = 1'b0;
    tring_wdata = in_raw_reading;
    pr_we       = 1'b0;

    // one restoring-division step
    r2 = {rem_r, dv_r[bpcf_pkg::DIV_W-1]};
    ge = (r2 >= {1'b0, den_r});
    sens = '0;
    ptmp = '0;
    pval = '0;
    pold = pvalid_r[ppos_r] ? pr_rdata : 18'd0;
    tsum_new = tsum_r - TSW'(tring_r[tpos_r]) + TSW'(in_raw_reading);
    psum_new = psum_r - PSW'(pold) + PSW'(pc_r);
    diff = $signed({1'b0, slowq_r}) - $signed({1'b0, fast_r});
    mag = '0;
    snew = '0;

    unique case (state_r)
      bpcf_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_op) begin
            tring_we = 1'b1;
            tsum_nxt = tsum_new;
            tpos_nxt = (tpos_r == TLAST) ? '0 : tpos_r + 1'b1;
            dv_nxt   = bpcf_pkg::DIV_W'(tsum_new) << (bpcf_pkg::DIV_W - TSW);
            rem_nxt  = '0;
            den_nxt  = TDEN;
            cnt_nxt  = bpcf_pkg::CNT_W'(TSW);
            state_nxt = bpcf_pkg::ST_TDIV;
          end else begin
            d1_nxt    = in_raw_reading;
            state_nxt = bpcf_pkg::ST_DT;
          end
        end
      end
      bpcf_pkg::ST_TDIV, bpcf_pkg::ST_FDIV, bpcf_pkg::ST_SDIV, bpcf_pkg::ST_ADIV: begin
        rem_nxt = ge ? bpcf_pkg::DEN_W'(r2 - {1'b0, den_r}) : r2[bpcf_pkg::DEN_W-1:0];
        dv_nxt  = {dv_r[bpcf_pkg::DIV_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == bpcf_pkg::CNT_W'(1)) begin
          priority case (state_r)
            bpcf_pkg::ST_TDIV: begin
              avg_nxt   = dv_nxt[23:0];
              state_nxt = bpcf_pkg::ST_DT;
            end
            bpcf_pkg::ST_FDIV: begin
              fast_nxt  = dv_nxt[25:0];
              state_nxt = bpcf_pkg::ST_SLOW;
            end
            bpcf_pkg::ST_SDIV: begin
              slowq_nxt = dv_nxt[25:0];
              state_nxt = bpcf_pkg::ST_ADJ;
            end
            default: begin
              state_nxt = bpcf_pkg::ST_FIN;
            end
          endcase
        end
      end
      bpcf_pkg::ST_DT: begin
        dt_nxt     = $signed({1'b0, avg_r}) - $signed({1'b0, c5_r, 8'd0});
        acc_nxt    = '0;
        mcand_nxt  = bpcf_pkg::MUL_W'(dt_nxt);
        mplier_nxt = {8'd0, c4_r};
        cnt_nxt    = bpcf_pkg::CNT_W'(bpcf_pkg::C4_BITS);
        state_nxt  = bpcf_pkg::ST_MOFF;
      end
      bpcf_pkg::ST_MOFF, bpcf_pkg::ST_MSENS, bpcf_pkg::ST_MP: begin
        // one multiplier bit: add, then advance
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == bpcf_pkg::CNT_W'(1)) begin
          priority case (state_r)
            bpcf_pkg::ST_MOFF:  state_nxt = bpcf_pkg::ST_OFF;
            bpcf_pkg::ST_MSENS: state_nxt = bpcf_pkg::ST_SENS;
            default:            state_nxt = bpcf_pkg::ST_PRES;
          endcase
        end
      end
      bpcf_pkg::ST_OFF: begin
        off_nxt = $signed({5'd0, c2_r, 16'd0}) + bpcf_pkg::OFF_W'(acc_r >>> 7);
        acc_nxt    = '0;
        mcand_nxt  = bpcf_pkg::MUL_W'(dt_r);
        mplier_nxt = {8'd0, c3_r};
        cnt_nxt    = bpcf_pkg::CNT_W'(bpcf_pkg::C4_BITS);
        state_nxt  = bpcf_pkg::ST_MSENS;
      end
      bpcf_pkg::ST_SENS: begin
        sens = $signed({5'd0, c1_r, 15'd0}) + bpcf_pkg::SENS_W'(acc_r >>> 8);
        acc_nxt    = '0;
        mcand_nxt  = bpcf_pkg::MUL_W'(sens);
        mplier_nxt = d1_r;
        cnt_nxt    = bpcf_pkg::CNT_W'(bpcf_pkg::D1_BITS);
        state_nxt  = bpcf_pkg::ST_MP;
      end
      bpcf_pkg::ST_PRES: begin
        ptmp = 40'(acc_r >>> 21) - 40'(off_r);
        pval = 25'(ptmp >>> 15);
        if (pval < 0) begin
          pc_nxt = '0;
        end else if (pval > $signed({7'd0, bpcf_pkg::P_MAX})) begin
          pc_nxt = bpcf_pkg::P_MAX;
        end else begin
          pc_nxt = pval[17:0];
        end
        state_nxt = bpcf_pkg::ST_PSUM;
      end
      bpcf_pkg::ST_PSUM: begin
        pr_we              = 1'b1;
        pvalid_nxt[ppos_r] = 1'b1;
        psum_nxt  = psum_new;
        ppos_nxt  = (ppos_r == PLAST) ? '0 : ppos_r + 1'b1;
        dv_nxt    = bpcf_pkg::DIV_W'({psum_new, 8'd0}) << (bpcf_pkg::DIV_W - FNW);
        rem_nxt   = '0;
        den_nxt   = PDEN;
        cnt_nxt   = bpcf_pkg::CNT_W'(FNW);
        state_nxt = bpcf_pkg::ST_FDIV;
      end
      bpcf_pkg::ST_SLOW: begin
        dv_nxt = bpcf_pkg::DIV_W'(slow_r) * bpcf_pkg::SLOW_KEEP
               + bpcf_pkg::DIV_W'(fast_r) * bpcf_pkg::SLOW_GAIN + bpcf_pkg::SLOW_RND;
        rem_nxt   = '0;
        den_nxt   = bpcf_pkg::SLOW_DEN;
        cnt_nxt   = bpcf_pkg::CNT_W'(bpcf_pkg::DIV_W);
        state_nxt = bpcf_pkg::ST_SDIV;
      end
      bpcf_pkg::ST_ADJ: begin
        // clamp to +-8 Pa, pull slow only outside the dead band
        if (diff > bpcf_pkg::DIFF_W'(bpcf_pkg::DIFF_CLAMP)) begin
          diff = bpcf_pkg::DIFF_W'(bpcf_pkg::DIFF_CLAMP);
        end else if (diff < -bpcf_pkg::DIFF_W'(bpcf_pkg::DIFF_CLAMP)) begin
          diff = -bpcf_pkg::DIFF_W'(bpcf_pkg::DIFF_CLAMP);
        end
        mag     = diff[bpcf_pkg::DIFF_W-1] ? bpcf_pkg::MAG_W'(-diff) : bpcf_pkg::MAG_W'(diff);
        neg_nxt = diff[bpcf_pkg::DIFF_W-1];
        rem_nxt = '0;
        den_nxt = bpcf_pkg::ADJ_DEN;
        cnt_nxt = bpcf_pkg::CNT_W'(bpcf_pkg::ADJ_BITS);
        if (mag > bpcf_pkg::MAG_W'(bpcf_pkg::DIFF_DEAD)) begin
          dv_nxt    = bpcf_pkg::DIV_W'(mag) << (bpcf_pkg::DIV_W - bpcf_pkg::ADJ_BITS);
          state_nxt = bpcf_pkg::ST_ADIV;
        end else begin
          dv_nxt    = '0;
          state_nxt = bpcf_pkg::ST_FIN;
        end
      end
      bpcf_pkg::ST_FIN: begin
        if (neg_r) begin
          snew = $signed({2'd0, slowq_r}) + $signed({19'd0, dv_r[bpcf_pkg::ADQ_W-1:0]});
        end else begin
          snew = $signed({2'd0, slowq_r}) - $signed({19'd0, dv_r[bpcf_pkg::ADQ_W-1:0]});
        end
        if (snew < 0) begin
          slow_nxt = '0;
        end else if (snew > $signed({2'd0, bpcf_pkg::SLOW_MAX})) begin
          slow_nxt = bpcf_pkg::SLOW_MAX;
        end else begin
          slow_nxt = snew[25:0];
        end
        state_nxt = bpcf_pkg::ST_OUT;
      end
      bpcf_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          opc_nxt    = pc_r;
          ofast_nxt  = fast_r;
          oslow_nxt  = slow_r;
          state_nxt  = bpcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpcf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bpcf_pkg::ST_IDLE;
      tpos_r   <= '0;
      tsum_r   <= '0;
      avg_r    <= '0;
      d1_r     <= '0;
      ppos_r   <= '0;
      psum_r   <= '0;
      pvalid_r <= '0;
      slow_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tpos_r   <= tpos_nxt;
      tsum_r   <= tsum_nxt;
      avg_r    <= avg_nxt;
      d1_r     <= d1_nxt;
      ppos_r   <= ppos_nxt;
      psum_r   <= psum_nxt;
      pvalid_r <= pvalid_nxt;
      slow_r   <= slow_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TEMP_TAPS; i++) begin
        tring_r[i] <= '0;
      end
    end else if (tring_we) begin
      tring_r[tpos_r] <= tring_wdata;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    dv_r     <= dv_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    dt_r     <= dt_nxt;
    off_r    <= off_nxt;
    pc_r     <= pc_nxt;
    fast_r   <= fast_nxt;
    slowq_r  <= slowq_nxt;
    neg_r    <= neg_nxt;
    opc_r    <= opc_nxt;
    ofast_r  <= ofast_nxt;
    oslow_r  <= oslow_nxt;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("item accepted but block not busy");

  a_temp_goes_to_divide: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_op |=> state_r == bpcf_pkg::ST_TDIV)
    else $error("temperature item skipped the average divide");

  a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r == bpcf_pkg::ST_OUT))
    else $error("result appeared outside the output step");

  a_ppos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpcf_pkg::ST_PSUM |-> ppos_r <= PLAST)
    else $error("pressure ring position out of range");

  a_tpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> tpos_r <= TLAST)
    else $error("temperature ring position out of range");
`endif

endmodule
